// ===== hdl/sorted_array_priority_queue_assert.svh =====
// Assertion macros used by the property module of the priority queue.
// Both sample on clk and are switched off while arst_n is low.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("priority queue property failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("priority queue property failed");

`endif

// ===== hdl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

	// request codes; the spare code behaves as a peek
	localparam logic [1:0] REQ_ENQ  = 2'd0;
	localparam logic [1:0] REQ_DEQ  = 2'd1;
	localparam logic [1:0] REQ_PEEK = 2'd2;

	// response status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic enq;
		logic deq;
	} spq_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/spq_req_if.sv =====
`default_nettype none

interface spq_req_if #(
	parameter int DATA_WIDTH = 16,
	parameter int PRIO_WIDTH = 8
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic [DATA_WIDTH-1:0] in_data;
	logic [PRIO_WIDTH-1:0] in_priority;

	modport source (output valid, output req_type, output in_data, output in_priority,
		input ready);
	modport sink (input valid, input req_type, input in_data, input in_priority,
		output ready);
endinterface

`default_nettype wire

// ===== hdl/spq_rsp_if.sv =====
`default_nettype none

interface spq_rsp_if #(
	parameter int DATA_WIDTH  = 16,
	parameter int PRIO_WIDTH  = 8,
	parameter int COUNT_WIDTH = 5
);
	logic                   valid;
	logic                   ready;
	logic [DATA_WIDTH-1:0]  out_data;
	logic [PRIO_WIDTH-1:0]  out_priority;
	logic [COUNT_WIDTH-1:0] entry_count;
	logic                   is_empty;
	logic                   is_full;
	logic [1:0]             status;

	modport source (output valid, output out_data, output out_priority,
		output entry_count, output is_empty, output is_full, output status, input ready);
	modport sink (input valid, input out_data, input out_priority,
		input entry_count, input is_empty, input is_full, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/spq_cell.sv =====
`default_nettype none

// One slot of the sorted chain. Slot 0 is the head; priorities fall towards
// the far end. On enqueue a slot takes its lower neighbour's entry when that
// neighbour moves out of the newcomer's way, takes the newcomer where it
// lands, else holds. On dequeue every slot takes its upper neighbour.
module spq_cell #(
	parameter int DATA_WIDTH = 16,
	parameter int PRIO_WIDTH = 8
) (
	input  wire                   clk,
	input  spq_pkg::spq_cmd_t     cmd,
	input  wire  [DATA_WIDTH-1:0] new_data,
	input  wire  [PRIO_WIDTH-1:0] new_prio,
	input  wire                   occ,
	input  wire                   below_occ,
	input  wire                   below_lt,
	input  wire  [DATA_WIDTH-1:0] below_data,
	input  wire  [PRIO_WIDTH-1:0] below_prio,
	input  wire  [DATA_WIDTH-1:0] above_data,
	input  wire  [PRIO_WIDTH-1:0] above_prio,
	output logic [DATA_WIDTH-1:0] data_q,
	output logic [PRIO_WIDTH-1:0] prio_q,
	output logic                  lt
);

	logic land;

	// newcomer ranks strictly above this entry, so the entry moves on
	assign lt   = occ && (prio_q < new_prio);
	// newcomer lands here: first slot it beats, or the first free slot
	assign land = lt || (below_occ && !occ);

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (below_lt) begin
				data_q <= below_data;
				prio_q <= below_prio;
			end else if (land) begin
				data_q <= new_data;
				prio_q <= new_prio;
			end
		end else if (cmd.deq) begin
			data_q <= above_data;
			prio_q <= above_prio;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sorted_array_priority_queue.sv =====
// The response is registered: it becomes valid in the cycle after a request is accepted.
// Throughput: one request per cycle, set by the update of the cell chain;
// a response not taken stalls the request side only while the output register is held.
// Reset: arst_n clears the entry count and the response valid; cell contents stay
// unknown until written and are never read beyond the count.
`default_nettype none

// Priority queue built as a chain of cells kept in descending priority order,
// so the head always sits in cell 0 and no wide read mux is needed.
//
// Enqueue: every occupied cell compares its priority with the newcomer in
// parallel. Cells with a strictly lower priority form a run at the far end of
// the chain; that run shifts one place away from the head and the newcomer
// drops into the gap. Equal priorities stay ahead, so earlier entries leave
// first. Dequeue: the whole chain shifts one place towards the head.
// Peek and the spare request code leave the chain untouched.
//
// Occupancy of each cell is derived from the entry count, so the store
// carries no valid bits of its own.
module sorted_array_priority_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 16,
	parameter int PRIO_WIDTH = 8
) (
	input wire      clk,
	input wire      arst_n,
	spq_req_if.sink req,
	spq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	// chain taps, one per cell
	logic [DATA_WIDTH-1:0] c_data [DEPTH];
	logic [PRIO_WIDTH-1:0] c_prio [DEPTH];
	logic                  c_lt   [DEPTH];
	logic                  c_occ  [DEPTH];

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic                  rsp_valid_q;
	logic                  accept;
	logic                  empty_now;
	logic                  full_now;
	spq_pkg::spq_cmd_t     cmd;
	logic [1:0]            st;
	logic [DATA_WIDTH-1:0] o_data;
	logic [PRIO_WIDTH-1:0] o_prio;

	// take a new request whenever the response register is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;

	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == CW'(DEPTH));

	// decode the request; the head is cell 0 before the step
	always_comb begin
		cmd     = '0;
		count_d = count_q;
		st      = spq_pkg::ST_OK;
		o_data  = c_data[0];
		o_prio  = c_prio[0];
		unique case (req.req_type)
			spq_pkg::REQ_ENQ: begin
				if (full_now) begin
					st = spq_pkg::ST_OVERFLOW;
				end else begin
					cmd.enq = accept;
					count_d = count_q + CW'(1);
					// newcomer becomes the head if it beats cell 0 or the chain is empty
					if (empty_now || c_lt[0]) begin
						o_data = req.in_data;
						o_prio = req.in_priority;
					end
				end
			end
			spq_pkg::REQ_DEQ: begin
				if (empty_now) begin
					st     = spq_pkg::ST_UNDERFLOW;
					o_data = '0;
					o_prio = '0;
				end else begin
					cmd.deq = accept;
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				// peek, and the spare code
				if (empty_now) begin
					st     = spq_pkg::ST_UNDERFLOW;
					o_data = '0;
					o_prio = '0;
				end
			end
		endcase
	end

	// build the chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  b_occ;
		logic                  b_lt;
		logic [DATA_WIDTH-1:0] b_data;
		logic [PRIO_WIDTH-1:0] b_prio;
		logic [DATA_WIDTH-1:0] a_data;
		logic [PRIO_WIDTH-1:0] a_prio;

		assign c_occ[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			// nothing ahead of the head: it never takes a shifted entry
			assign b_occ  = 1'b1;
			assign b_lt   = 1'b0;
			assign b_data = '0;
			assign b_prio = '0;
		end else begin : g_body
			assign b_occ  = c_occ[i-1];
			assign b_lt   = c_lt[i-1];
			assign b_data = c_data[i-1];
			assign b_prio = c_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			// last cell holds its own value on dequeue; it falls out of the count
			assign a_data = c_data[i];
			assign a_prio = c_prio[i];
		end else begin : g_inner
			assign a_data = c_data[i+1];
			assign a_prio = c_prio[i+1];
		end

		spq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.PRIO_WIDTH (PRIO_WIDTH)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.new_data   (req.in_data),
			.new_prio   (req.in_priority),
			.occ        (c_occ[i]),
			.below_occ  (b_occ),
			.below_lt   (b_lt),
			.below_data (b_data),
			.below_prio (b_prio),
			.above_data (a_data),
			.above_prio (a_prio),
			.data_q     (c_data[i]),
			.prio_q     (c_prio[i]),
			.lt         (c_lt[i])
		);
	end

	// entry count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload: load with each accepted request, hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp.out_data     <= o_data;
			rsp.out_priority <= o_prio;
			rsp.entry_count  <= count_d;
			rsp.is_empty     <= (count_d == '0);
			rsp.is_full      <= (count_d == CW'(DEPTH));
			rsp.status       <= st;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/spq_props.sv =====
`default_nettype none
`include "sorted_array_priority_queue_assert.svh"

module spq_props #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 16,
	parameter int PRIO_WIDTH = 8
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  rsp_valid,
	input wire                  rsp_ready,
	input wire [DATA_WIDTH-1:0] out_data,
	input wire [PRIO_WIDTH-1:0] out_priority,
	input wire [$clog2(DEPTH+1)-1:0] entry_count,
	input wire                  is_empty,
	input wire                  is_full,
	input wire [1:0]            status
);

	localparam int CW = $clog2(DEPTH + 1);

	// a stalled response holds its payload
	`SPQ_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_data) && $stable(out_priority) && $stable(entry_count) && $stable(status))

	// flags agree with the count
	`SPQ_ASSERT_IMPL(a_flags, rsp_valid, (is_empty == (entry_count == '0)) && (is_full == (entry_count == CW'(DEPTH))))

	// an overflow only happens on a full queue
	`SPQ_ASSERT_IMPL(a_overflow, rsp_valid && (status == spq_pkg::ST_OVERFLOW), is_full)

	// an underflow leaves the queue empty and returns no entry
	`SPQ_ASSERT_IMPL(a_underflow, rsp_valid && (status == spq_pkg::ST_UNDERFLOW), is_empty && (out_data == '0) && (out_priority == '0))

endmodule

bind sorted_array_priority_queue spq_props #(
	.DEPTH      (DEPTH),
	.DATA_WIDTH (DATA_WIDTH),
	.PRIO_WIDTH (PRIO_WIDTH)
) u_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.out_data     (rsp.out_data),
	.out_priority (rsp.out_priority),
	.entry_count  (rsp.entry_count),
	.is_empty     (rsp.is_empty),
	.is_full      (rsp.is_full),
	.status       (rsp.status)
);

`default_nettype wire
